[hdl/mqfb_pkg.sv]
// Shared command and status codes for the multi-queue FIFO bank.
`timescale 1ns / 1ps

package mqfb_pkg;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BAD_INDEX = 2'd3
   } status_type;

   localparam int unsigned CFG_WIDTH     = 5;
   localparam int unsigned CMD_WIDTH     = 2;
   localparam int unsigned INDEX_WIDTH   = 4;
   localparam int unsigned VALUE_WIDTH   = 32;
   localparam logic [CFG_WIDTH-1:0] QUEUES_RESET = 5'd16;

endpackage

[hdl/mqfb_ram.sv]
// Generic simple dual-port RAM with registered read and read enable.
`timescale 1ns / 1ps

module mqfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/multi_queue_fifo_bank.sv]
// Top level: bank of independent FIFO queues sharing one entry store.
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless rsp_ready stalls, set by the
// single pass through input register, per-queue pointer update and store port.
// Reset clears all head and tail pointers and fill counts and sets queues in
// use to 16; the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module multi_queue_fifo_bank
   import mqfb_pkg::*;
#(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CFG_WIDTH-1:0]          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CMD_WIDTH-1:0]          req_cmd,
   input  logic [INDEX_WIDTH-1:0]        req_queue_index,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_is_empty
);

   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW        = $clog2(QUEUE_DEPTH);
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_QUEUES * (2 ** PW);
   localparam int AW        = $clog2(RAM_DEPTH);
   localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL  = CW'(QUEUE_DEPTH);

   // configuration
   logic [CFG_WIDTH-1:0] queues_in_use_ff;

   // input register
   logic                   a_valid_ff;
   logic [CMD_WIDTH-1:0]   a_cmd_ff;
   logic [INDEX_WIDTH-1:0] a_index_ff;
   logic [VALUE_WIDTH-1:0] a_value_ff;

   // per-queue state
   logic [PW-1:0] head_ff [NUM_QUEUES];
   logic [PW-1:0] tail_ff [NUM_QUEUES];
   logic [CW-1:0] cnt_ff  [NUM_QUEUES];
   logic [PW-1:0] head_in;
   logic [PW-1:0] tail_in;
   logic [CW-1:0] cnt_in;

   // result register
   logic                   b_valid_ff;
   status_type             b_status_ff;
   logic                   b_empty_ff;
   logic                   b_from_ram_ff;
   logic [VALUE_WIDTH-1:0] b_value_ff;
   status_type             b_status_in;
   logic                   b_empty_in;
   logic                   b_from_ram_in;
   logic [VALUE_WIDTH-1:0] b_value_in;

   logic                  advance;
   logic [QW-1:0]         qsel;
   logic                  bad_index;
   logic [PW-1:0]         cur_head;
   logic [PW-1:0]         cur_tail;
   logic [CW-1:0]         cur_cnt;
   logic                  do_enq;
   logic                  do_deq;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   assign advance   = a_valid_ff && (!b_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         queues_in_use_ff <= QUEUES_RESET;
      end else if (csr_wr_en) begin
         queues_in_use_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         a_cmd_ff   <= req_cmd;
         a_index_ff <= req_queue_index;
         a_value_ff <= req_value;
      end
   end

   assign qsel      = QW'(a_index_ff);
   assign bad_index = ({1'b0, a_index_ff} >= queues_in_use_ff)
                   || ({28'd0, a_index_ff} >= 32'(NUM_QUEUES));
   assign cur_head  = head_ff[qsel];
   assign cur_tail  = tail_ff[qsel];
   assign cur_cnt   = cnt_ff[qsel];
   assign wr_data   = DATA_WIDTH'(a_value_ff);

   always_comb begin
      do_enq        = 1'b0;
      do_deq        = 1'b0;
      b_status_in   = STAT_OK;
      b_empty_in    = 1'b0;
      b_from_ram_in = 1'b0;
      b_value_in    = '0;
      if (bad_index) begin
         b_status_in = STAT_BAD_INDEX;
      end else begin
         unique case (cmd_type'(a_cmd_ff))
            CMD_ENQUEUE: begin
               if (cur_cnt == CNT_FULL) begin
                  b_status_in = STAT_FULL;
               end else begin
                  do_enq     = 1'b1;
                  b_value_in = VALUE_WIDTH'(wr_data);
               end
            end
            CMD_DEQUEUE: begin
               if (cur_cnt == '0) begin
                  b_status_in = STAT_EMPTY;
                  b_empty_in  = 1'b1;
               end else begin
                  do_deq        = 1'b1;
                  b_from_ram_in = 1'b1;
                  b_empty_in    = (cur_cnt == CW'(1));
               end
            end
            default: begin
               b_empty_in = (cur_cnt == '0);
            end
         endcase
      end
   end

   assign tail_in = (cur_tail == PTR_LAST) ? '0 : cur_tail + PW'(1);
   assign head_in = (cur_head == PTR_LAST) ? '0 : cur_head + PW'(1);
   assign cnt_in  = do_enq ? cur_cnt + CW'(1) : cur_cnt - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (advance) begin
         if (do_enq) begin
            tail_ff[qsel] <= tail_in;
            cnt_ff[qsel]  <= cnt_in;
         end
         if (do_deq) begin
            head_ff[qsel] <= head_in;
            cnt_ff[qsel]  <= cnt_in;
         end
      end
   end

   assign wr_addr = AW'({qsel, cur_tail});
   assign rd_addr = AW'({qsel, cur_head});

   mqfb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (advance && do_enq),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance && do_deq),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_status_ff   <= b_status_in;
         b_empty_ff    <= b_empty_in;
         b_from_ram_ff <= b_from_ram_in;
         b_value_ff    <= b_value_in;
      end
   end

   assign rsp_valid        = b_valid_ff;
   assign rsp_result_value = b_from_ram_ff ? VALUE_WIDTH'(rd_data) : b_value_ff;
   assign rsp_status       = b_status_ff;
   assign rsp_is_empty     = b_empty_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> cur_cnt <= CNT_FULL)
      else $error("queue fill count beyond depth");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_status_ff == STAT_FULL |-> !b_empty_ff)
      else $error("full result flagged empty");

   a_enq_counts: assert property (@(posedge clock) disable iff (reset)
      advance && do_enq |=> cnt_ff[$past(qsel)] == $past(cur_cnt) + CW'(1))
      else $error("enqueue did not advance fill count");

   a_deq_counts: assert property (@(posedge clock) disable iff (reset)
      advance && do_deq |=> cnt_ff[$past(qsel)] == $past(cur_cnt) - CW'(1))
      else $error("dequeue did not reduce fill count");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> a_valid_ff && b_valid_ff && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

[tb/sv/multi_queue_fifo_bank_tb.sv]
// Testbench for the multi-queue FIFO bank: directed table, then predictor-checked random traffic.
`timescale 1ns / 1ps

module multi_queue_fifo_bank_tb
   import mqfb_pkg::*;
();

   localparam int NUM_QUEUES   = 16;
   localparam int QUEUE_DEPTH  = 64;
   localparam int PHASE_ITEMS  = 40;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   localparam logic [CMD_WIDTH-1:0]   CMD_SPARE = 2'd3;
   localparam logic [VALUE_WIDTH-1:0] VAL_MIN   = 32'h8000_0000;
   localparam logic [VALUE_WIDTH-1:0] VAL_MAX   = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
      logic                   empty;
   } op_result_type;

   typedef enum logic {ROW_TXN, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CMD_WIDTH-1:0]   cmd;
      logic [INDEX_WIDTH-1:0] idx;
      logic [VALUE_WIDTH-1:0] value;
      logic                   has_exp;
      op_result_type          exp;
   } dir_row_type;

   localparam op_result_type UNTYPED = '0;

   localparam dir_row_type DIRECTED [0:26] = '{
      '{ROW_TXN, CMD_QUERY,   4'd0,  32'd0,         1'b1, '{32'd0, STAT_OK, 1'b1}},
      '{ROW_TXN, CMD_DEQUEUE, 4'd15, 32'd0,         1'b1, '{32'd0, STAT_EMPTY, 1'b1}},
      '{ROW_TXN, CMD_ENQUEUE, 4'd0,  VAL_MIN,       1'b1, '{VAL_MIN, STAT_OK, 1'b0}},
      '{ROW_TXN, CMD_ENQUEUE, 4'd0,  VAL_MAX,       1'b1, '{VAL_MAX, STAT_OK, 1'b0}},
      '{ROW_TXN, CMD_ENQUEUE, 4'd15, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, STAT_OK, 1'b0}},
      '{ROW_TXN, CMD_SPARE,   4'd0,  32'hDEAD_BEEF, 1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd0,  32'h1234_5678, 1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd0,  32'd0,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_QUERY,   4'd0,  VAL_MAX,       1'b0, UNTYPED},
      '{ROW_TXN, CMD_ENQUEUE, 4'd7,  32'h5555_5555, 1'b0, UNTYPED},
      '{ROW_TXN, CMD_ENQUEUE, 4'd7,  32'hAAAA_AAAA, 1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd7,  32'd0,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd15, 32'd0,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd15, 32'd0,         1'b0, UNTYPED},
      '{ROW_CFG, CMD_ENQUEUE, 4'd0,  32'd1,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_ENQUEUE, 4'd1,  VAL_MAX,       1'b1, '{32'd0, STAT_BAD_INDEX, 1'b0}},
      '{ROW_TXN, CMD_SPARE,   4'd15, 32'd0,         1'b1, '{32'd0, STAT_BAD_INDEX, 1'b0}},
      '{ROW_TXN, CMD_ENQUEUE, 4'd0,  32'd1,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd0,  32'd0,         1'b0, UNTYPED},
      '{ROW_CFG, CMD_ENQUEUE, 4'd0,  32'd0,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_QUERY,   4'd0,  32'd0,         1'b1, '{32'd0, STAT_BAD_INDEX, 1'b0}},
      '{ROW_TXN, CMD_ENQUEUE, 4'd0,  VAL_MIN,       1'b1, '{32'd0, STAT_BAD_INDEX, 1'b0}},
      '{ROW_CFG, CMD_ENQUEUE, 4'd0,  32'd31,        1'b0, UNTYPED},
      '{ROW_TXN, CMD_ENQUEUE, 4'd15, 32'h8000_0001, 1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd15, 32'd0,         1'b0, UNTYPED},
      '{ROW_TXN, CMD_DEQUEUE, 4'd7,  32'd0,         1'b0, UNTYPED},
      '{ROW_CFG, CMD_ENQUEUE, 4'd0,  32'd16,        1'b0, UNTYPED}
   };

   localparam logic [CFG_WIDTH-1:0] RUN_COUNTS [0:6] = '{
      5'd16, 5'd1, 5'd9, 5'd31, 5'd0, 5'd4, 5'd16
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_wr_en;
   logic [CFG_WIDTH-1:0]          csr_wr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [CMD_WIDTH-1:0]          req_cmd;
   logic [INDEX_WIDTH-1:0]        req_queue_index;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [VALUE_WIDTH-1:0] rsp_result_value;
   logic [1:0]                    rsp_status;
   logic                          rsp_is_empty;

   logic [VALUE_WIDTH-1:0] ring_store [0:NUM_QUEUES*QUEUE_DEPTH-1];
   logic [5:0]             head_ptr   [0:NUM_QUEUES-1];
   logic [5:0]             tail_ptr   [0:NUM_QUEUES-1];
   logic [6:0]             fill_level [0:NUM_QUEUES-1];
   logic [CFG_WIDTH-1:0]   queues_in_use_cfg;

   op_result_type pending_results [$];
   int            mismatch_count = 0;
   int            req_run = 0;
   int            rsp_run = 0;

   multi_queue_fifo_bank dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_queue_index  (req_queue_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty)
   );

   always #2 clock = ~clock;

   function automatic int draw_wait(inout int run);
      if (run > 0) begin
         run = run - 1;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         run = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic void predict_queue_op(input logic [CMD_WIDTH-1:0] cmd,
                                            input logic [INDEX_WIDTH-1:0] idx,
                                            input logic [VALUE_WIDTH-1:0] val,
                                            output op_result_type r);
      r = '0;
      r.status = STAT_OK;
      if ({1'b0, idx} >= queues_in_use_cfg) begin
         r.status = STAT_BAD_INDEX;
         return;
      end
      if (cmd == CMD_ENQUEUE) begin
         if (fill_level[idx] == QUEUE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            ring_store[{idx, tail_ptr[idx]}] = val;
            tail_ptr[idx] = tail_ptr[idx] + 6'd1;
            fill_level[idx] = fill_level[idx] + 7'd1;
            r.value = val;
         end
      end else if (cmd == CMD_DEQUEUE) begin
         if (fill_level[idx] == 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.value = ring_store[{idx, head_ptr[idx]}];
            head_ptr[idx] = head_ptr[idx] + 6'd1;
            fill_level[idx] = fill_level[idx] - 7'd1;
         end
      end
      r.empty = (fill_level[idx] == 0);
   endfunction

   task automatic send_op(input logic [CMD_WIDTH-1:0] cmd,
                          input logic [INDEX_WIDTH-1:0] idx,
                          input logic [VALUE_WIDTH-1:0] val);
      int            gap;
      op_result_type r;
      gap = draw_wait(req_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_queue_index <= idx;
      req_value       <= val;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_queue_op(cmd, idx, val, r);
      pending_results.push_back(r);
   endtask

   task automatic set_queue_count(input logic [CFG_WIDTH-1:0] n);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      queues_in_use_cfg = n;
   endtask

   initial begin
      logic [CMD_WIDTH-1:0]   op;
      logic [INDEX_WIDTH-1:0] q;
      logic [VALUE_WIDTH-1:0] v;
      int                     span;
      int                     pick;

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_cmd         = CMD_QUERY;
      req_queue_index = '0;
      req_value       = '0;
      queues_in_use_cfg = QUEUES_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_ptr[i]   = '0;
         tail_ptr[i]   = '0;
         fill_level[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            set_queue_count(DIRECTED[i].value[CFG_WIDTH-1:0]);
         end else begin
            send_op(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].value);
            if (DIRECTED[i].has_exp)
               pending_results[pending_results.size() - 1] = DIRECTED[i].exp;
         end
      end

      for (int p = 0; p < $size(RUN_COUNTS); p++) begin
         set_queue_count(RUN_COUNTS[p]);
         span = (int'(queues_in_use_cfg) > NUM_QUEUES) ? NUM_QUEUES
                                                       : int'(queues_in_use_cfg);
         if (p == 0) begin
            // fill one queue past full, then drain it past empty
            q = INDEX_WIDTH'($urandom_range(0, NUM_QUEUES - 1));
            repeat (QUEUE_DEPTH + 2) send_op(CMD_ENQUEUE, q, $urandom());
            send_op(CMD_QUERY, q, $urandom());
            repeat (QUEUE_DEPTH + 2) send_op(CMD_DEQUEUE, q, $urandom());
         end
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
               op = CMD_ENQUEUE;
            else if (pick < 16)
               op = CMD_DEQUEUE;
            else if (pick < 19)
               op = CMD_QUERY;
            else
               op = CMD_SPARE;
            if (span > 0 && $urandom_range(0, 4) != 0)
               q = INDEX_WIDTH'($urandom_range(0, span - 1));
            else
               q = INDEX_WIDTH'($urandom_range(0, NUM_QUEUES - 1));
            case ($urandom_range(0, 7))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               default: v = $urandom();
            endcase
            send_op(op, q, v);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("multi_queue_fifo_bank_tb: PASS");
      else
         $display("multi_queue_fifo_bank_tb: FAIL");
      $finish;
   end

   initial begin
      op_result_type got;
      op_result_type want;
      int            gap;

      rsp_ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = draw_wait(rsp_run);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.value  = rsp_result_value;
         got.status = status_type'(rsp_status);
         got.empty  = rsp_is_empty;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected transaction: value %h status %0d empty %0b",
                        got.value, got.status, got.empty);
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.empty !== want.empty) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display(
                     "mismatch: expected %h status %0d empty %0b, got %h status %0d empty %0b",
                     want.value, want.status, want.empty,
                     got.value, got.status, got.empty);
            end
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("multi_queue_fifo_bank_tb: FAIL");
      $finish;
   end

endmodule
